// ===== rtl/core/dtps_pkg.sv =====
package dtps_pkg;

    localparam int STEP_W = 5;
    localparam int RANGE_W = 20;
    localparam logic [RANGE_W-1:0] EMPTY_RANGE = '1;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_SHIFT_X  = 3'd0,
        REG_SHIFT_Y  = 3'd1,
        REG_SHIFT_Z  = 3'd2,
        REG_SKIP     = 3'd3,
        REG_GND_SLP  = 3'd4,
        REG_GND_BAND = 3'd5,
        REG_VIEW_SLP = 3'd6,
        REG_NEAR     = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_TEST1,
        ST_TEST2,
        ST_PATH,
        ST_CORDIC,
        ST_GAIN,
        ST_RANGE,
        ST_BIN,
        ST_LOOK,
        ST_MERGE,
        ST_READ,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              clr_en;
        logic              mul_en;
        logic              test1_en;
        logic              test2_en;
        logic              path_en;
        logic              cordic_en;
        logic              gain_en;
        logic              range_en;
        logic              bin_en;
        logic              rd_en;
        logic              merge_en;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        kind_t in_kind;
        logic  in_take;
        logic  clr_last;
        logic  drop;
        logic  x_pos;
        logic  axis;
        logic  bin_ok;
        logic  out_busy;
    } dp_status_t;

    // atan(2^-i) in units of pi/2^31
    function automatic logic signed [31:0] arc_step(input logic [STEP_W-1:0] i);
        logic signed [31:0] v;
        unique case (i)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/dtps_ctrl.sv =====
module dtps_ctrl
    import dtps_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid)
                begin
                    unique case (status.in_kind)
                        KIND_FRAME: state_next = ST_CLEAR;
                        KIND_PIXEL: state_next = status.in_take ? ST_MUL : ST_IDLE;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            ST_MUL:
                if (step_reg == STEP_W'(2)) state_next = ST_TEST1;
            ST_TEST1:
                state_next = ST_TEST2;
            ST_TEST2:
                state_next = ST_PATH;
            ST_PATH:
                priority if (status.drop) state_next = ST_IDLE;
                else if (status.x_pos)    state_next = ST_CORDIC;
                else if (status.axis)     state_next = ST_BIN;
                else                      state_next = ST_IDLE;
            ST_CORDIC:
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_GAIN;
            ST_GAIN:
                state_next = ST_RANGE;
            ST_RANGE:
                state_next = ST_BIN;
            ST_BIN:
                state_next = ST_LOOK;
            ST_LOOK:
                state_next = status.bin_ok ? ST_MERGE : ST_IDLE;
            ST_MERGE:
                state_next = ST_IDLE;
            ST_READ:
                state_next = ST_RESULT;
            ST_RESULT:
                if (!status.out_busy) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        step_next = '0;
        if ((state_reg == ST_MUL || state_reg == ST_CORDIC) && state_next == state_reg)
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.step = step_reg;
        unique case (state_reg)
            ST_CLEAR:  cmd.clr_en = 1'b1;
            ST_IDLE:   cmd.accept = 1'b1;
            ST_MUL:    cmd.mul_en = 1'b1;
            ST_TEST1:  cmd.test1_en = 1'b1;
            ST_TEST2:  cmd.test2_en = 1'b1;
            ST_PATH:   cmd.path_en = 1'b1;
            ST_CORDIC: cmd.cordic_en = 1'b1;
            ST_GAIN:   cmd.gain_en = 1'b1;
            ST_RANGE:  cmd.range_en = 1'b1;
            ST_BIN:    cmd.bin_en = 1'b1;
            ST_LOOK:   cmd.rd_en = 1'b1;
            ST_MERGE:  cmd.merge_en = 1'b1;
            ST_READ:   cmd.rd_en = 1'b1;
            ST_RESULT: cmd.out_load = !status.out_busy;
            default:   cmd.step = step_reg;
        endcase
    end

    assign s_tready = cmd.accept;

endmodule

// ===== rtl/core/dtps_datapath.sv =====
module dtps_datapath
    import dtps_pkg::*;
#(
    parameter int NUM_BINS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  status
);

    localparam int BW = $clog2(NUM_BINS);

    // configuration
    logic signed [15:0]  shift_x_reg, shift_y_reg, shift_z_reg;
    logic [15:0]         skip_cfg_reg, gnd_slope_reg, gnd_band_reg, view_slope_reg;
    logic [RANGE_W-1:0]  near_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_x_reg    <= '0;
            shift_y_reg    <= '0;
            shift_z_reg    <= '0;
            skip_cfg_reg   <= '0;
            gnd_slope_reg  <= '0;
            gnd_band_reg   <= '0;
            view_slope_reg <= '1;
            near_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_SHIFT_X:  shift_x_reg    <= cfg_data[15:0];
                REG_SHIFT_Y:  shift_y_reg    <= cfg_data[15:0];
                REG_SHIFT_Z:  shift_z_reg    <= cfg_data[15:0];
                REG_SKIP:     skip_cfg_reg   <= cfg_data[15:0];
                REG_GND_SLP:  gnd_slope_reg  <= cfg_data[15:0];
                REG_GND_BAND: gnd_band_reg   <= cfg_data[15:0];
                REG_VIEW_SLP: view_slope_reg <= cfg_data[15:0];
                REG_NEAR:     near_reg       <= cfg_data;
                default:      near_reg       <= near_reg;
            endcase
        end
    end

    // input transfer
    logic        in_fire;
    kind_t       in_kind;
    logic [15:0] skip_reg;

    assign in_fire = s_tvalid && cmd.accept;
    assign in_kind = kind_t'(s_tuser);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= '0;
        end
        else if (in_fire)
        begin
            if (in_kind == KIND_FRAME)
            begin
                skip_reg <= '0;
            end
            else if (in_kind == KIND_PIXEL)
            begin
                skip_reg <= (skip_reg == '0) ? skip_cfg_reg : skip_reg - 16'd1;
            end
        end
    end

    logic [15:0]        depth_reg;
    logic signed [15:0] fwd_reg, side_reg, up_reg;
    logic [BW-1:0]      bin_reg;
    logic               oob_reg;

    // point = round(depth * ray) + shift
    logic signed [15:0] ray_sel, shift_sel;
    logic signed [32:0] pt_prod, pt_rnd;
    logic signed [18:0] pt_raw;
    logic signed [19:0] pt_val;
    logic signed [19:0] x_reg, y_reg, z_reg;
    logic signed [18:0] zr_reg;

    always_comb
    begin
        unique case (cmd.step[1:0])
            2'd0:    begin ray_sel = fwd_reg;  shift_sel = shift_x_reg; end
            2'd1:    begin ray_sel = side_reg; shift_sel = shift_y_reg; end
            default: begin ray_sel = up_reg;   shift_sel = shift_z_reg; end
        endcase
    end

    assign pt_prod = $signed({1'b0, depth_reg}) * ray_sel;
    assign pt_rnd  = pt_prod + 33'sd8192;
    assign pt_raw  = pt_rnd[32:14];
    assign pt_val  = {pt_raw[18], pt_raw} + {{4{shift_sel[15]}}, shift_sel};

    // slope and band tests
    logic [19:0] abs_x, abs_z;
    logic [18:0] abs_zr;
    logic [35:0] gnd_rhs, view_rhs;
    logic        gnd_drop_reg, view_drop_reg;

    assign abs_x    = x_reg[19] ? 20'(-x_reg) : 20'(x_reg);
    assign abs_z    = z_reg[19] ? 20'(-z_reg) : 20'(z_reg);
    assign abs_zr   = zr_reg[18] ? 19'(-zr_reg) : 19'(zr_reg);
    assign gnd_rhs  = gnd_slope_reg * abs_x;
    assign view_rhs = view_slope_reg * abs_x;

    // CORDIC vectoring
    logic signed [31:0] cx_reg, cy_reg, ang_reg;
    logic signed [31:0] cx_sh, cy_sh;
    logic signed [31:0] arc;

    assign cx_sh = cx_reg >>> cmd.step;
    assign cy_sh = cy_reg >>> cmd.step;
    assign arc   = arc_step(cmd.step);

    logic [61:0]        gain_reg;
    logic [61:0]        gain_rnd;
    logic [RANGE_W-1:0] range_reg;

    assign gain_rnd = gain_reg + (62'd1 << 37);

    // binning
    logic signed [32:0] ang_off;
    logic               in_span;
    logic [43:0]        u_prod;
    logic [12:0]        u_bin;
    logic               bin_ok_reg;

    assign ang_off = {ang_reg[31], ang_reg} + 33'sd1073741824;
    assign in_span = !ang_off[32] && !ang_off[31];
    assign u_prod  = 44'(ang_off[30:0]) * 44'(NUM_BINS);
    assign u_bin   = u_prod[43:31];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            depth_reg <= s_tdata[15:0];
            fwd_reg   <= s_tdata[31:16];
            side_reg  <= s_tdata[47:32];
            up_reg    <= s_tdata[63:48];
            bin_reg   <= BW'(s_tdata[72:65]);
            oob_reg   <= 32'(s_tdata[72:65]) >= NUM_BINS;
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.step[1:0])
                2'd0:    x_reg <= pt_val;
                2'd1:    y_reg <= pt_val;
                default: begin z_reg <= pt_val; zr_reg <= pt_raw; end
            endcase
        end
        if (cmd.test1_en)
        begin
            gnd_drop_reg <= (36'({abs_z, 12'b0}) < gnd_rhs) || (abs_z < 20'(gnd_band_reg));
        end
        if (cmd.test2_en)
        begin
            view_drop_reg <= 36'({abs_zr, 12'b0}) > view_rhs;
        end
        if (cmd.path_en)
        begin
            cx_reg    <= 32'(x_reg) <<< 8;
            cy_reg    <= 32'(y_reg) <<< 8;
            ang_reg   <= status.x_pos ? 32'sd0 : -32'sd1073741824;
            range_reg <= 20'(-y_reg);
        end
        if (cmd.cordic_en)
        begin
            if (!cy_reg[31])
            begin
                cx_reg  <= cx_reg + cy_sh;
                cy_reg  <= cy_reg - cx_sh;
                ang_reg <= ang_reg + arc;
            end
            else
            begin
                cx_reg  <= cx_reg - cy_sh;
                cy_reg  <= cy_reg + cx_sh;
                ang_reg <= ang_reg - arc;
            end
        end
        if (cmd.gain_en)
        begin
            gain_reg <= 62'($unsigned(cx_reg)) * 62'(GAIN_Q30);
        end
        if (cmd.range_en)
        begin
            range_reg <= (|gain_rnd[61:58]) ? EMPTY_RANGE : gain_rnd[57:38];
        end
        if (cmd.bin_en)
        begin
            bin_reg    <= u_bin[BW-1:0];
            bin_ok_reg <= in_span && (range_reg > near_reg) && (u_bin < 13'(NUM_BINS));
        end
    end

    // bin store: {hit, range}
    logic [RANGE_W:0] mem [NUM_BINS];
    logic [RANGE_W:0] rdata_reg;
    logic [BW-1:0]    clr_idx_reg;
    logic             mem_we;
    logic [BW-1:0]    mem_waddr;
    logic [RANGE_W:0] mem_wdata;
    logic             rd_hit;
    logic [RANGE_W-1:0] rd_range;

    assign rd_hit   = rdata_reg[RANGE_W];
    assign rd_range = rdata_reg[RANGE_W-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = bin_reg;
        mem_wdata = {1'b1, range_reg};
        if (cmd.clr_en)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = {1'b0, EMPTY_RANGE};
        end
        else if (cmd.merge_en)
        begin
            mem_we = !rd_hit || (range_reg < rd_range);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[bin_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_idx_reg <= status.clr_last ? '0 : clr_idx_reg + BW'(1);
        end
    end

    // result register
    logic               out_valid_reg;
    logic [RANGE_W-1:0] out_range_reg;
    logic               out_empty_reg;
    logic               hit_ok;

    assign hit_ok = rd_hit && !oob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_range_reg <= hit_ok ? rd_range : EMPTY_RANGE;
            out_empty_reg <= !hit_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_range_reg};
    assign m_tuser  = out_empty_reg;

    assign status.in_kind  = in_kind;
    assign status.in_take  = (in_kind == KIND_PIXEL) && (skip_reg == '0) && s_tdata[64];
    assign status.clr_last = clr_idx_reg == BW'(NUM_BINS - 1);
    assign status.drop     = gnd_drop_reg || view_drop_reg;
    assign status.x_pos    = !x_reg[19] && (x_reg != '0);
    assign status.axis     = (x_reg == '0) && y_reg[19];
    assign status.bin_ok   = bin_ok_reg;
    assign status.out_busy = out_valid_reg && !m_tready;

endmodule

// ===== rtl/core/depth_to_planar_scan.sv =====
// Depth pixels to a planar range scan, binned over -90..+90 degrees.
// Input stream s_*: tuser is the item kind (frame start, pixel, read bin).
//   Frame start empties all bins and restarts pixel skipping.
//   Pixel forms depth*ray+shift, applies ground, band and view tests, then CORDIC
//   (skipped on -y axis) gives angle and range, then near test; bin keeps its minimum.
//   Read returns one bin on m_*: tdata bin_range, tuser bin_empty.
// Configuration: cfg_we/cfg_addr/cfg_data; the user must write it only while idle, the block does not enforce this.
// The sequencer runs one item at a time. A used pixel takes 3 shared point
// multiplies, 2 tests, a path choice, CORDIC_STEPS vectoring iterations,
// gain, range, bin, and a read-modify-write; a skipped pixel or one dropped
// early ends sooner; a read waits out an output stall before loading.
// Frame start empties the bin store, one entry cleared per cycle.
// After reset a clearing pass runs with s_tready low.
// A read result sits in the output register; a stalled receiver holds
// only a following read, other items keep flowing.
module depth_to_planar_scan
    import dtps_pkg::*;
#(
    parameter int NUM_BINS     = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // depth_mm, ray_fwd, ray_side, ray_up, ray_ok, bin_select
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // bin_range
    output logic        m_tuser,   // bin_empty
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    dtps_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dtps_datapath #(
        .NUM_BINS(NUM_BINS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== rtl/core/dtps_checker.sv =====
module dtps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 24'h0FFFFF)
        else $error("empty bin without sentinel range");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("input taken during clearing pass");

endmodule

bind depth_to_planar_scan dtps_checker u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
